// ===== design/assert_macros.svh =====
// Assertion macros shared by the queue, front and back design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, suspended while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Clocked check that also runs during reset
`define ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ===== design/ifsp_pkg.sv =====
`default_nettype none
package ifsp_pkg;

  // Geometry
  localparam int MAX_WIDTH  = 512;
  localparam int HEIGHT_CAP = 512;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int CFG_DIM_W  = 10;
  localparam int COLN_W     = $clog2(MAX_WIDTH + 1);
  localparam int COL_W      = (COLN_W > CFG_DIM_W) ? COLN_W : CFG_DIM_W;
  localparam int ROW_W      = 10;

  // Data widths
  localparam int PIX_W    = 8;
  localparam int WEIGHT_W = 16;
  localparam int SUM_W    = 12;
  localparam int P1_W     = SUM_W + WEIGHT_W;
  localparam int DIFF_W   = 30;
  localparam int PROD_W   = DIFF_W + WEIGHT_W + 1;
  localparam int ACC_W    = 48;
  localparam int LINE_W   = 3 * PIX_W;

  // Item queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUR_WEIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_GAIN    = 2'd3;

  // Reset values
  localparam logic [CFG_DIM_W-1:0] IMAGE_WIDTH_RST  = 10'd512;
  localparam logic [CFG_DIM_W-1:0] IMAGE_HEIGHT_RST = 10'd512;
  localparam logic [WEIGHT_W-1:0]  BLUR_WEIGHT_RST  = 16'd7274;
  localparam logic [WEIGHT_W-1:0]  STEP_GAIN_RST    = 16'd1311;
  localparam logic [PIX_W-1:0]     PIX_MAX          = 8'd255;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] image_width;
    logic [CFG_DIM_W-1:0] image_height;
    logic [WEIGHT_W-1:0]  blur_weight;
    logic [WEIGHT_W-1:0]  step_gain;
  } cfg_t;

  // One classified item, front to back
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  f;
    logic [PIX_W-1:0]  g;
    logic              has_result;
    logic              left_edge;
    logic              right_edge;
    logic              top_edge;
    logic              bottom_edge;
    logic              last;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage
`default_nettype wire

// ===== design/inverse_filter_stencil_pass_top.sv =====
// Sequencing, set by the back sequencer: an item that yields no result takes the idle
//   and read states (line-buffer RAM read); one that yields a result then takes two
//   multiply stages and a done state, which holds while the output stalls. A result
//   belongs to the pixel W+1 items earlier. The input side buffers up to 4 items.
// Reset: counters, window, queue and output valid cleared, registers to defaults; the line
//   buffers are not cleared and need no clearing pass.
`default_nettype none
module inverse_filter_stencil_pass_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [ifsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ifsp_pkg::WEIGHT_W-1:0]   cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [ifsp_pkg::PIX_W-1:0]      current_pixel,
  input  wire logic [ifsp_pkg::PIX_W-1:0]      observed_pixel,
  input  wire logic                            flush,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [ifsp_pkg::PIX_W-1:0]           new_pixel,
  output logic                                 frame_last
);

  ifsp_pkg::cfg_t      cfg;
  ifsp_pkg::item_t     push_item, head;
  ifsp_pkg::q_status_t q_status;
  logic                push, pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= ifsp_pkg::IMAGE_WIDTH_RST;
      cfg.image_height <= ifsp_pkg::IMAGE_HEIGHT_RST;
      cfg.blur_weight  <= ifsp_pkg::BLUR_WEIGHT_RST;
      cfg.step_gain    <= ifsp_pkg::STEP_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ifsp_pkg::REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[ifsp_pkg::CFG_DIM_W-1:0];
        ifsp_pkg::REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[ifsp_pkg::CFG_DIM_W-1:0];
        ifsp_pkg::REG_BLUR_WEIGHT:  cfg.blur_weight  <= cfg_data;
        ifsp_pkg::REG_STEP_GAIN:    cfg.step_gain    <= cfg_data;
        default: ;
      endcase
    end
  end

  ifsp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .current_pixel (current_pixel),
    .observed_pixel(observed_pixel),
    .flush         (flush),
    .q_status      (q_status),
    .push          (push),
    .push_item     (push_item)
  );

  ifsp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  ifsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .new_pixel (new_pixel),
    .frame_last(frame_last)
  );

endmodule
`default_nettype wire

// ===== design/ifsp_ram.sv =====
`default_nettype none
module ifsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/ifsp_queue.sv =====
`default_nettype none
`include "assert_macros.svh"
module ifsp_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  ifsp_pkg::item_t     push_item,
  input  wire logic           pop,
  output ifsp_pkg::item_t     head,
  output ifsp_pkg::q_status_t status
);

  ifsp_pkg::item_t               entries [ifsp_pkg::QUEUE_DEPTH];
  logic [ifsp_pkg::QPTR_W-1:0]   wr_ptr;
  logic [ifsp_pkg::QPTR_W-1:0]   rd_ptr;
  logic [ifsp_pkg::QCNT_W-1:0]   count;

  assign status.empty = (count == '0);
  assign status.full  = (count == ifsp_pkg::QCNT_W'(ifsp_pkg::QUEUE_DEPTH));
  assign head         = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == ifsp_pkg::QPTR_W'(ifsp_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == ifsp_pkg::QPTR_W'(ifsp_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_CLK(a_count_bound, clk, rst, count <= ifsp_pkg::QCNT_W'(ifsp_pkg::QUEUE_DEPTH))
  `ASSERT_CLK(a_no_pop_empty, clk, rst, pop |-> (count != '0))

endmodule
`default_nettype wire

// ===== design/ifsp_front.sv =====
`default_nettype none
`include "assert_macros.svh"
module ifsp_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  ifsp_pkg::cfg_t                   cfg,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [ifsp_pkg::PIX_W-1:0]  current_pixel,
  input  wire logic [ifsp_pkg::PIX_W-1:0]  observed_pixel,
  input  wire logic                        flush,
  input  ifsp_pkg::q_status_t              q_status,
  output logic                             push,
  output ifsp_pkg::item_t                  push_item
);

  logic [ifsp_pkg::COL_W-1:0] column_count, column_count_next;
  logic [ifsp_pkg::ROW_W-1:0] row_count, row_count_next;

  logic [ifsp_pkg::COL_W-1:0] iw, w_eff, c, cc, c_inc;
  logic [ifsp_pkg::ROW_W-1:0] h_eff, r1, r, cr, r_inc;
  logic                       pad, has_result, last;

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  // Effective frame size
  always_comb begin
    iw = ifsp_pkg::COL_W'(cfg.image_width);
    if (iw == '0) begin
      w_eff = ifsp_pkg::COL_W'(1);
    end else if (iw > ifsp_pkg::COL_W'(ifsp_pkg::MAX_WIDTH)) begin
      w_eff = ifsp_pkg::COL_W'(ifsp_pkg::MAX_WIDTH);
    end else begin
      w_eff = iw;
    end
    if (cfg.image_height == '0) begin
      h_eff = ifsp_pkg::ROW_W'(1);
    end else if (cfg.image_height > ifsp_pkg::ROW_W'(ifsp_pkg::HEIGHT_CAP)) begin
      h_eff = ifsp_pkg::ROW_W'(ifsp_pkg::HEIGHT_CAP);
    end else begin
      h_eff = cfg.image_height;
    end
  end

  // Position, padding and result classification
  always_comb begin
    if (column_count >= w_eff) begin
      c  = '0;
      r1 = row_count + 1'b1;
    end else begin
      c  = column_count;
      r1 = row_count;
    end
    r   = (r1 > h_eff + 1'b1) ? '0 : r1;
    pad = flush || (r >= h_eff);

    if (c != '0) begin
      has_result = (r != '0);
      cr         = r - 1'b1;
      cc         = c - 1'b1;
    end else begin
      has_result = (r >= ifsp_pkg::ROW_W'(2));
      cr         = r - ifsp_pkg::ROW_W'(2);
      cc         = w_eff - 1'b1;
    end
    if (cr >= h_eff) begin
      has_result = 1'b0;
    end
    last = (cr == h_eff - 1'b1) && (cc == w_eff - 1'b1);

    c_inc = c + 1'b1;
    r_inc = r + 1'b1;
    if (c_inc >= w_eff) begin
      column_count_next = '0;
      row_count_next    = r_inc;
    end else begin
      column_count_next = c_inc;
      row_count_next    = r;
    end
    if (has_result && last) begin
      column_count_next = '0;
      row_count_next    = '0;
    end

    push_item.addr        = c[ifsp_pkg::ADDR_W-1:0];
    push_item.f           = pad ? '0 : current_pixel;
    push_item.g           = pad ? '0 : observed_pixel;
    push_item.has_result  = has_result;
    push_item.left_edge   = (cc == '0);
    push_item.right_edge  = (cc == w_eff - 1'b1);
    push_item.top_edge    = (cr == '0);
    push_item.bottom_edge = (cr == h_eff - 1'b1);
    push_item.last        = last;
  end

  // Position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (push) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  `ASSERT_CLK(a_frame_restart, clk, rst, (push && push_item.has_result && push_item.last) |=> (column_count == '0 && row_count == '0))

endmodule
`default_nettype wire

// ===== design/ifsp_back.sv =====
`default_nettype none
`include "assert_macros.svh"
module ifsp_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  ifsp_pkg::cfg_t                   cfg,
  input  ifsp_pkg::item_t                  head,
  input  ifsp_pkg::q_status_t              q_status,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [ifsp_pkg::PIX_W-1:0]       new_pixel,
  output logic                             frame_last
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_MUL1 = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state, state_next;

  logic [ifsp_pkg::PIX_W-1:0]  win [9];
  logic [ifsp_pkg::PIX_W-1:0]  win_next [9];
  logic [ifsp_pkg::PIX_W-1:0]  hold_g;
  logic [ifsp_pkg::PIX_W-1:0]  g_center;
  logic [ifsp_pkg::PIX_W-1:0]  f_center;
  logic                        last_flag;
  logic [ifsp_pkg::SUM_W-1:0]  sum, sum_next;
  logic [ifsp_pkg::P1_W-1:0]   p1;
  logic signed [ifsp_pkg::DIFF_W-1:0] diff;
  logic signed [ifsp_pkg::PROD_W-1:0] prod;
  logic signed [ifsp_pkg::ACC_W-1:0]  acc;
  logic [ifsp_pkg::PIX_W-1:0]  result;
  logic                        load_out;

  logic [ifsp_pkg::LINE_W-1:0] ram_rdata, ram_wdata;
  logic                        ram_we;
  logic [ifsp_pkg::PIX_W-1:0]  upper_rd, middle_rd, obs_rd;

  // Line buffers: upper, middle and observed delay share one address
  ifsp_ram #(
    .WIDTH(ifsp_pkg::LINE_W),
    .DEPTH(ifsp_pkg::MAX_WIDTH)
  ) u_lines (
    .clk  (clk),
    .we   (ram_we),
    .waddr(head.addr),
    .wdata(ram_wdata),
    .raddr(head.addr),
    .rdata(ram_rdata)
  );

  assign upper_rd  = ram_rdata[3*ifsp_pkg::PIX_W-1:2*ifsp_pkg::PIX_W];
  assign middle_rd = ram_rdata[2*ifsp_pkg::PIX_W-1:ifsp_pkg::PIX_W];
  assign obs_rd    = ram_rdata[ifsp_pkg::PIX_W-1:0];
  assign ram_we    = (state == ST_READ);
  assign ram_wdata = {middle_rd, head.f, head.g};
  assign pop       = (state == ST_READ);

  // Window shift and masked tap sum
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      win_next[k] = win[k+3];
    end
    win_next[6] = upper_rd;
    win_next[7] = middle_rd;
    win_next[8] = head.f;
    sum_next = '0;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        if (!((k == 0 && head.left_edge) || (k == 2 && head.right_edge) ||
              (j == 0 && head.top_edge) || (j == 2 && head.bottom_edge))) begin
          sum_next = sum_next + ifsp_pkg::SUM_W'(win_next[k*3+j]);
        end
      end
    end
  end

  // Update arithmetic: D = g*2^16 - w*S, T = f*2^32 + gain*D
  always_comb begin
    diff = $signed({6'b0, g_center, 16'b0}) - $signed({2'b0, p1});
    acc  = $signed({8'b0, f_center, 32'b0}) + {prod[ifsp_pkg::PROD_W-1], prod};
    if (acc[ifsp_pkg::ACC_W-1]) begin
      result = '0;
    end else if (acc[ifsp_pkg::ACC_W-2:32] > 15'(ifsp_pkg::PIX_MAX)) begin
      result = ifsp_pkg::PIX_MAX;
    end else begin
      result = acc[39:32];
    end
  end

  assign load_out = (state == ST_DONE) && (!out_valid || !out_stall);

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (!q_status.empty) state_next = ST_READ;
      ST_READ: state_next = head.has_result ? ST_MUL1 : ST_IDLE;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_DONE;
      ST_DONE: if (load_out) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == ST_READ) begin
        for (int k = 0; k < 9; k++) begin
          win[k] <= win_next[k];
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      hold_g    <= obs_rd;
      g_center  <= hold_g;
      f_center  <= win_next[4];
      sum       <= sum_next;
      last_flag <= head.last;
    end
    if (state == ST_MUL1) begin
      p1 <= cfg.blur_weight * sum;
    end
    if (state == ST_MUL2) begin
      prod <= $signed({1'b0, cfg.step_gain}) * diff;
    end
    if (load_out) begin
      new_pixel  <= result;
      frame_last <= last_flag;
    end
  end

  `ASSERT_CLK(a_read_after_idle, clk, rst, (state == ST_READ) |-> $past(state == ST_IDLE && !q_status.empty))
  `ASSERT_CLK(a_result_from_done, clk, rst, $rose(out_valid) |-> $past(state == ST_DONE))

endmodule
`default_nettype wire

// ===== verif/inverse_filter_stencil_pass_top_tb.sv =====
`default_nettype none
module inverse_filter_stencil_pass_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ifsp_pkg::*;

  localparam int SETTLE_CYCLES  = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1350;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic             last;
  } pix_result_t;

  // DUT ports
  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WEIGHT_W-1:0]  cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     current_pixel = '0;
  logic [PIX_W-1:0]     observed_pixel = '0;
  logic                 flush = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PIX_W-1:0]     new_pixel;
  logic                 frame_last;

  inverse_filter_stencil_pass_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .current_pixel  (current_pixel),
    .observed_pixel (observed_pixel),
    .flush          (flush),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .new_pixel      (new_pixel),
    .frame_last     (frame_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor state: register copy, line stores, tap window, position
  cfg_t             cfg;
  logic [PIX_W-1:0] up_row [MAX_WIDTH];
  logic [PIX_W-1:0] mid_row [MAX_WIDTH];
  logic [PIX_W-1:0] g_line [MAX_WIDTH];
  logic [PIX_W-1:0] g_hold;
  logic [PIX_W-1:0] taps [9];
  int               col_pos;
  int               row_pos;
  bit               frame_done;

  pix_result_t expected_pixels[$];
  int          item_count = 0;
  int          err_count = 0;
  int          burst_left = 0;
  int          stall_run = 0;
  int          quiet_cycles = 0;

  function automatic void note_error(string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  function automatic int width_eff();
    int w;
    w = cfg.image_width;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int height_eff();
    int h;
    h = cfg.image_height;
    if (h < 1) h = 1;
    if (h > HEIGHT_CAP) h = HEIGHT_CAP;
    return h;
  endfunction

  function automatic void stencil_reset();
    cfg = '{IMAGE_WIDTH_RST, IMAGE_HEIGHT_RST, BLUR_WEIGHT_RST, STEP_GAIN_RST};
    foreach (up_row[i]) begin
      up_row[i] = '0;
      mid_row[i] = '0;
      g_line[i] = '0;
    end
    foreach (taps[i]) taps[i] = '0;
    g_hold = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  // One accepted input transaction through the predictor
  function automatic void stencil_step(logic [PIX_W-1:0] f_px, logic [PIX_W-1:0] g_px,
                                       logic fl);
    int w, h, r, c, cr, cc;
    logic pad, hit, last_px;
    logic [PIX_W-1:0] f_in, g_in, t_top, t_mid, g_ctr, px;
    longint sum, diff, acc;
    w = width_eff();
    h = height_eff();
    // position wraps if the registers shrank under it
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos > h + 1) row_pos = 0;
    r = row_pos;
    c = col_pos;
    pad = fl || (r >= h);
    f_in = pad ? '0 : f_px;
    g_in = pad ? '0 : g_px;

    t_top = up_row[c];
    t_mid = mid_row[c];
    up_row[c] = t_mid;
    mid_row[c] = f_in;
    for (int k = 0; k < 6; k++) taps[k] = taps[k + 3];
    taps[6] = t_top;
    taps[7] = t_mid;
    taps[8] = f_in;

    g_ctr = g_hold;
    g_hold = g_line[c];
    g_line[c] = g_in;

    // centre of the window trails the input by one row and one column
    hit = 1'b0;
    cr = 0;
    cc = 0;
    if (c >= 1) begin
      if (r >= 1) begin
        hit = 1'b1;
        cr = r - 1;
        cc = c - 1;
      end
    end else if (r >= 2) begin
      hit = 1'b1;
      cr = r - 2;
      cc = w - 1;
    end
    if (hit && cr >= h) hit = 1'b0;

    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
    end
    if (!hit) return;

    // zero padding: drop taps outside the frame
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        if ((k == 0 && cc == 0) || (k == 2 && cc == w - 1)) continue;
        if ((j == 0 && cr == 0) || (j == 2 && cr == h - 1)) continue;
        sum += taps[k * 3 + j];
      end
    end
    diff = longint'(g_ctr) * 65536 - longint'(cfg.blur_weight) * sum;
    acc = longint'(taps[4]) * (longint'(1) << 32) + longint'(cfg.step_gain) * diff;
    if (acc < 0) px = '0;
    else if ((acc >>> 32) > 255) px = PIX_MAX;
    else px = acc[39:32];

    last_px = (cr == h - 1) && (cc == w - 1);
    if (last_px) begin
      col_pos = 0;
      row_pos = 0;
      frame_done = 1'b1;
    end
    expected_pixels.push_back('{px, last_px});
  endfunction

  function automatic logic [PIX_W-1:0] rand_px();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return PIX_MAX;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return BLUR_WEIGHT_RST;
      3, 4: return WEIGHT_W'($urandom_range(6500, 8000));
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return STEP_GAIN_RST;
      3, 4: return WEIGHT_W'($urandom_range(0, 20000));
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  // Receiver: stall runs mixed with longer stall-free runs
  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_run <= $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
      stall_run <= $urandom_range(0, 29);
    end
  end

  // Result checker
  always @(posedge clk) begin
    pix_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        note_error($sformatf("unexpected result: new_pixel=%0d frame_last=%0b",
                             new_pixel, frame_last));
      end else begin
        want = expected_pixels.pop_front();
        if (new_pixel !== want.px || frame_last !== want.last)
          note_error($sformatf("new_pixel exp %0d got %0d, frame_last exp %0b got %0b",
                               want.px, new_pixel, want.last, frame_last));
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("inverse_filter_stencil_pass_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one input transaction; sender runs in bursts with random gaps
  task automatic send_item(input logic [PIX_W-1:0] f_px, input logic [PIX_W-1:0] g_px,
                           input logic fl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    current_pixel <= f_px;
    observed_pixel <= g_px;
    flush <= fl;
    do @(posedge clk); while (in_stall);
    stencil_step(f_px, g_px, fl);
    item_count++;
  endtask

  // Quiet the input and let every expected result come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] data);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  cfg.image_width = data[CFG_DIM_W-1:0];
      REG_IMAGE_HEIGHT: cfg.image_height = data[CFG_DIM_W-1:0];
      REG_BLUR_WEIGHT:  cfg.blur_weight = data;
      REG_STEP_GAIN:    cfg.step_gain = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Dimension writes carry junk above the 10-bit field
  task automatic set_config(input int w, input int h, input logic [WEIGHT_W-1:0] wt,
                            input logic [WEIGHT_W-1:0] gn);
    write_reg(REG_IMAGE_WIDTH, (WEIGHT_W'($urandom) << CFG_DIM_W) | WEIGHT_W'(w));
    write_reg(REG_IMAGE_HEIGHT, (WEIGHT_W'($urandom) << CFG_DIM_W) | WEIGHT_W'(h));
    write_reg(REG_BLUR_WEIGHT, wt);
    write_reg(REG_STEP_GAIN, gn);
  endtask

  // One frame of random pixels plus its drain; a noisy frame is cut short or overrun
  task automatic send_frame(input bit noisy);
    int n, extra;
    n = width_eff() * height_eff();
    extra = width_eff() + 1;
    if (noisy) begin
      if ($urandom_range(0, 1) == 0) n = $urandom_range(0, n - 1);
      else extra += $urandom_range(1, width_eff() + 3);
    end
    for (int i = 0; i < n; i++) send_item(rand_px(), rand_px(), $urandom_range(0, 31) == 0);
    for (int i = 0; i < extra; i++) send_item(rand_px(), rand_px(), $urandom_range(0, 3) != 0);
  endtask

  // Flush until the predictor sees the frame's last pixel
  task automatic drain_to_frame_end();
    if (col_pos == 0 && row_pos == 0) return;
    frame_done = 1'b0;
    while (!frame_done) send_item(rand_px(), rand_px(), 1'b1);
  endtask

  // Default coefficients, flush inside a frame, pixel after the frame
  task automatic test_default_coeffs();
    write_reg(REG_IMAGE_WIDTH, 16'd3);
    write_reg(REG_IMAGE_HEIGHT, 16'd2);
    send_item(8'd0, 8'd0, 1'b0);
    send_item(PIX_MAX, PIX_MAX, 1'b0);
    send_item(PIX_MAX, 8'd0, 1'b0);
    send_item(8'd0, PIX_MAX, 1'b0);
    send_item(8'd77, 8'd200, 1'b1);
    send_item(PIX_MAX, 8'd1, 1'b0);
    send_item(8'd200, 8'd200, 1'b0);
    repeat (3) send_item(rand_px(), rand_px(), 1'b1);
  endtask

  // Saturation at both ends of the clamp
  task automatic test_coeff_extremes();
    set_config(2, 2, '0, '1);
    send_item(PIX_MAX, PIX_MAX, 1'b0);
    send_item(8'd0, PIX_MAX, 1'b0);
    send_item(PIX_MAX, 8'd0, 1'b0);
    send_item(8'd1, 8'd254, 1'b0);
    repeat (3) send_item(rand_px(), rand_px(), 1'b1);
    set_config(2, 2, '1, '1);
    send_item(PIX_MAX, 8'd0, 1'b0);
    send_item(8'd0, 8'd0, 1'b0);
    send_item(PIX_MAX, PIX_MAX, 1'b0);
    send_item(8'd128, 8'd128, 1'b0);
    repeat (3) send_item(rand_px(), rand_px(), 1'b1);
  endtask

  // Width and height at and beyond their limits
  task automatic test_dimension_limits();
    set_config(0, 0, pick_weight(), pick_gain());
    send_frame(1'b0);
    set_config(1, 1023, pick_weight(), pick_gain());
    send_frame(1'b0);
    set_config(1023, 2, pick_weight(), pick_gain());
    send_frame(1'b0);
    set_config(512, 1, pick_weight(), pick_gain());
    send_frame(1'b0);
    set_config(2, 512, pick_weight(), pick_gain());
    send_frame(1'b0);
  endtask

  // Registers changed part way through a frame
  task automatic test_midframe_reconfig();
    int n;
    repeat (4) begin
      set_config($urandom_range(2, 8), $urandom_range(2, 6), pick_weight(), pick_gain());
      n = $urandom_range(1, width_eff() * height_eff());
      for (int i = 0; i < n; i++) send_item(rand_px(), rand_px(), $urandom_range(0, 15) == 0);
      set_config($urandom_range(1, 8), $urandom_range(1, 6), pick_weight(), pick_gain());
      n = $urandom_range(0, 20);
      for (int i = 0; i < n; i++) send_item(rand_px(), rand_px(), $urandom_range(0, 15) == 0);
      drain_to_frame_end();
    end
  endtask

  // Random frames over random settings, mostly well formed
  task automatic test_random_frames();
    int stop_at;
    int w, h;
    stop_at = item_count + RANDOM_ITEMS;
    while (item_count < stop_at) begin
      if ($urandom_range(0, 2) == 0) begin
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        set_config(w, h, pick_weight(), pick_gain());
      end
      send_frame($urandom_range(0, 7) == 0);
    end
    drain_to_frame_end();
  endtask

  initial begin
    stencil_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_default_coeffs();
    test_coeff_extremes();
    test_dimension_limits();
    test_midframe_reconfig();
    test_random_frames();
    wait_idle();
    if (err_count == 0) begin
      $display("inverse_filter_stencil_pass_top: match");
    end else begin
      $display("inverse_filter_stencil_pass_top: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
